// File: hw/rtl/kcit_pkg.sv
// ----------------------------------------------------------------------------
// kcit_pkg: shared types and constants
// Request and status codes, default table size, and the control structs
// passed between the top level and the tag search unit.
// ----------------------------------------------------------------------------
package kcit_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned PID_W  = 32;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned PORT_W = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_GET    = 2'd2,
    REQ_SET    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // tag store write command
  typedef struct packed {
    logic we;
    logic valid;
  } tag_wr_t;

  // search outcome, qualified by done
  typedef struct packed {
    logic done;
    logic hit;
    logic has_free;
  } scan_res_t;

endpackage

// File: hw/rtl/kcit_tag_search.sv
// ----------------------------------------------------------------------------
// kcit_tag_search: sequential key search over the tag store
// Holds {valid, key} per slot in a registered-read memory. One shared
// 64-bit comparator walks the slots; also finds the lowest free slot.
// ----------------------------------------------------------------------------
module kcit_tag_search #(
  parameter int unsigned ENTRIES = kcit_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kcit_pkg::KEY_W-1:0]  key,
  input  kcit_pkg::tag_wr_t           wr,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [kcit_pkg::KEY_W-1:0]  wr_key,
  output logic                        ready,
  output kcit_pkg::scan_res_t         res,
  output logic [IDX_W-1:0]            hit_idx,
  output logic [IDX_W-1:0]            free_idx
);
  import kcit_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} state_t;

  logic [KEY_W:0]   tag_mem [ENTRIES];
  logic [KEY_W:0]   tag_q_r;

  state_t           state_r;
  logic [IDX_W-1:0] idx_r;
  logic             issue_done_r;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             done_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [KEY_W:0]   mem_wd;
  logic             mem_re;
  logic             cur_hit;

  // clearing pass owns the write port until the table is empty
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = idx_r;
      mem_wd = '0;
    end else begin
      mem_we = wr.we;
      mem_wa = wr_addr;
      mem_wd = {wr.valid, wr_key};
    end
  end

  assign mem_re  = (state_r == S_SCAN) && !issue_done_r;
  assign cur_hit = tag_q_r[KEY_W] && (tag_q_r[KEY_W-1:0] == key);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      tag_q_r <= tag_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      pend_r       <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            hit_r        <= 1'b0;
            free_r       <= 1'b0;
            pend_r       <= 1'b0;
            issue_done_r <= 1'b0;
            idx_r        <= '0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue side: one read per cycle
          if (!issue_done_r) begin
            pend_r     <= 1'b1;
            pend_idx_r <= idx_r;
            if (idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            pend_r <= 1'b0;
          end
          // compare side: data of the previous read
          if (pend_r) begin
            if (cur_hit) begin
              hit_r     <= 1'b1;
              hit_idx_r <= pend_idx_r;
            end
            if (!tag_q_r[KEY_W] && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= pend_idx_r;
            end
            if (cur_hit || (pend_idx_r == LAST_IDX)) begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign ready        = (state_r != S_CLEAR);
  assign res.done     = done_r;
  assign res.hit      = hit_r;
  assign res.has_free = free_r;
  assign hit_idx      = hit_idx_r;
  assign free_idx     = free_idx_r;

endmodule

// File: hw/rtl/keyed_connection_info_table_core.sv
// ----------------------------------------------------------------------------
// keyed_connection_info_table_core: keyed table of connection records
// Associative table of process id, IPv4 address and port keyed by a
// 64-bit handle, with insert-or-update, remove, get and field-wise set.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A request walks the tag store one slot
// per cycle through a single shared key comparator, stopping at the first
// match. In the worst case (a miss, or a hit in the last slot) the walk
// covers every slot; a get adds a data read after the walk. in_stall is
// high from accept until the result is loaded into the result beat
// register. After reset the block clears the tag store, one slot per
// cycle, and holds in_stall high until the clearing pass ends. The result
// register parts the two sides: a new beat is taken while a finished
// result still waits on out_stall.
// ----------------------------------------------------------------------------
module keyed_connection_info_table_core #(
  parameter int unsigned ENTRIES = kcit_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [kcit_pkg::KEY_W-1:0]  in_key,
  input  logic [kcit_pkg::PID_W-1:0]  in_pid_value,
  input  logic [kcit_pkg::IP_W-1:0]   in_ip_value,
  input  logic [kcit_pkg::PORT_W-1:0] in_port_value,
  input  logic                        in_set_pid,
  input  logic                        in_set_ip,
  input  logic                        in_set_port,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [kcit_pkg::PID_W-1:0]  out_pid,
  output logic [kcit_pkg::IP_W-1:0]   out_ip,
  output logic [kcit_pkg::PORT_W-1:0] out_port
);
  import kcit_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  typedef enum logic [2:0] {T_IDLE, T_SCAN, T_GETRD, T_RESP} state_t;

  // record store: separate arrays so a set writes only enabled fields
  logic [PID_W-1:0]  pid_mem  [ENTRIES];
  logic [IP_W-1:0]   ip_mem   [ENTRIES];
  logic [PORT_W-1:0] port_mem [ENTRIES];
  logic [PID_W-1:0]  pid_q_r;
  logic [IP_W-1:0]   ip_q_r;
  logic [PORT_W-1:0] port_q_r;

  state_t            state_r;

  // captured request
  req_t              req_r;
  logic [KEY_W-1:0]  key_r;
  logic [PID_W-1:0]  pid_r;
  logic [IP_W-1:0]   ip_r;
  logic [PORT_W-1:0] port_r;
  logic              set_pid_r;
  logic              set_ip_r;
  logic              set_port_r;

  // pending result
  status_t           res_status_r;
  logic [PID_W-1:0]  res_pid_r;
  logic [IP_W-1:0]   res_ip_r;
  logic [PORT_W-1:0] res_port_r;

  // result beat register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [PID_W-1:0]  out_pid_r;
  logic [IP_W-1:0]   out_ip_r;
  logic [PORT_W-1:0] out_port_r;

  logic              in_accept;
  logic              srch_ready;
  scan_res_t         srch_res;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;

  tag_wr_t           tag_wr;
  logic [IDX_W-1:0]  tag_wa;
  logic              decide;
  logic              we_pid;
  logic              we_ip;
  logic              we_port;
  logic              dat_re;
  logic [IDX_W-1:0]  dat_addr;
  status_t           dec_status;
  logic              out_free;
  logic              out_load;

  assign in_stall  = !((state_r == T_IDLE) && srch_ready);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == T_RESP) && out_free;

  kcit_tag_search #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .key      (key_r),
    .wr       (tag_wr),
    .wr_addr  (tag_wa),
    .wr_key   (key_r),
    .ready    (srch_ready),
    .res      (srch_res),
    .hit_idx  (hit_idx),
    .free_idx (free_idx)
  );

  // Decision once the walk is done: a hit uses the matching slot, an insert
  // miss takes the lowest free slot or reports full, other misses not found.
  assign decide   = (state_r == T_SCAN) && srch_res.done;
  assign dat_addr = srch_res.hit ? hit_idx : free_idx;
  assign tag_wa   = dat_addr;

  always_comb begin
    tag_wr     = '0;
    we_pid     = 1'b0;
    we_ip      = 1'b0;
    we_port    = 1'b0;
    dat_re     = 1'b0;
    dec_status = ST_OK;
    case (req_r)
      REQ_INSERT: begin
        if (srch_res.hit || srch_res.has_free) begin
          we_pid  = decide;
          we_ip   = decide;
          we_port = decide;
          // new key claims the free slot
          tag_wr.we    = decide && !srch_res.hit;
          tag_wr.valid = 1'b1;
        end else begin
          dec_status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (srch_res.hit) begin
          tag_wr.we    = decide;
          tag_wr.valid = 1'b0;
        end else begin
          dec_status = ST_NOTFOUND;
        end
      end
      REQ_GET: begin
        if (srch_res.hit) begin
          dat_re = decide;
        end else begin
          dec_status = ST_NOTFOUND;
        end
      end
      REQ_SET: begin
        if (srch_res.hit) begin
          we_pid  = decide && set_pid_r;
          we_ip   = decide && set_ip_r;
          we_port = decide && set_port_r;
        end else begin
          dec_status = ST_NOTFOUND;
        end
      end
      default: begin
        dec_status = ST_NOTFOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_pid) begin
      pid_mem[dat_addr] <= pid_r;
    end
    if (we_ip) begin
      ip_mem[dat_addr] <= ip_r;
    end
    if (we_port) begin
      port_mem[dat_addr] <= port_r;
    end
    if (dat_re) begin
      pid_q_r  <= pid_mem[dat_addr];
      ip_q_r   <= ip_mem[dat_addr];
      port_q_r <= port_mem[dat_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // new result beat, or the waiting one taken downstream
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (in_accept) begin
            req_r      <= req_t'(in_req_type);
            key_r      <= in_key;
            pid_r      <= in_pid_value;
            ip_r       <= in_ip_value;
            port_r     <= in_port_value;
            set_pid_r  <= in_set_pid;
            set_ip_r   <= in_set_ip;
            set_port_r <= in_set_port;
            state_r    <= T_SCAN;
          end
        end
        T_SCAN: begin
          if (srch_res.done) begin
            res_status_r <= dec_status;
            res_pid_r    <= '0;
            res_ip_r     <= '0;
            res_port_r   <= '0;
            state_r      <= dat_re ? T_GETRD : T_RESP;
          end
        end
        T_GETRD: begin
          res_pid_r  <= pid_q_r;
          res_ip_r   <= ip_q_r;
          res_port_r <= port_q_r;
          state_r    <= T_RESP;
        end
        T_RESP: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_pid_r    <= res_pid_r;
            out_ip_r     <= res_ip_r;
            out_port_r   <= res_port_r;
            state_r      <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_pid    = out_pid_r;
  assign out_ip     = out_ip_r;
  assign out_port   = out_port_r;

endmodule

// File: bench/tb_keyed_connection_info_table_core.sv
// ----------------------------------------------------------------------------
// tb_keyed_connection_info_table_core: request/reply check of the keyed table
// Drives insert, remove, get and set requests and keeps a shadow copy of the
// table that predicts every reply beat. Each reply is checked field by field.
// A short directed part comes first. Random traffic on a small pool of
// handles follows, under four pacing phases of sender gaps and receiver stall.
// ----------------------------------------------------------------------------
module tb_keyed_connection_info_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import kcit_pkg::*;

  localparam int unsigned TBL_SLOTS = ENTRIES_DEF;
  // Handle pool for random traffic. It is a bit larger than the table, so
  // the table runs full now and then, and most lookups still hit.
  localparam int unsigned POOL_SIZE = 22;
  localparam int unsigned PHASE_REQS = 260;

  // one request beat, as driven on the in_ ports
  typedef struct {
    req_t              kind;
    logic [KEY_W-1:0]  key;
    logic [PID_W-1:0]  pid;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic              set_pid;
    logic              set_ip;
    logic              set_port;
  } conn_req_t;

  // one reply beat, as seen on the out_ ports
  typedef struct {
    status_t           status;
    logic [PID_W-1:0]  pid;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } conn_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_req_type = REQ_GET;
  logic [KEY_W-1:0]    in_key = '0;
  logic [PID_W-1:0]    in_pid_value = '0;
  logic [IP_W-1:0]     in_ip_value = '0;
  logic [PORT_W-1:0]   in_port_value = '0;
  logic                in_set_pid = 1'b0;
  logic                in_set_ip = 1'b0;
  logic                in_set_port = 1'b0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic [PID_W-1:0]    out_pid;
  logic [IP_W-1:0]     out_ip;
  logic [PORT_W-1:0]   out_port;

  // Shadow of the table contents, updated as each request beat is accepted
  logic                shadow_valid [TBL_SLOTS];
  logic [KEY_W-1:0]    shadow_key   [TBL_SLOTS];
  logic [PID_W-1:0]    shadow_pid   [TBL_SLOTS];
  logic [IP_W-1:0]     shadow_ip    [TBL_SLOTS];
  logic [PORT_W-1:0]   shadow_port  [TBL_SLOTS];

  conn_reply_t         awaited_replies [$];
  logic [KEY_W-1:0]    handle_pool [POOL_SIZE];

  // pacing knobs, in percent per cycle
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;

  int unsigned         mismatches = 0;
  int unsigned         req_count [4] = '{0, 0, 0, 0};
  int unsigned         replies_ok = 0;
  int unsigned         replies_missing = 0;
  int unsigned         replies_full = 0;

  keyed_connection_info_table_core #(
    .ENTRIES(TBL_SLOTS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_key       (in_key),
    .in_pid_value (in_pid_value),
    .in_ip_value  (in_ip_value),
    .in_port_value(in_port_value),
    .in_set_pid   (in_set_pid),
    .in_set_ip    (in_set_ip),
    .in_set_port  (in_set_port),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_pid      (out_pid),
    .out_ip       (out_ip),
    .out_port     (out_port)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure: a new coin flip at every falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Shadow table: computes the reply for one accepted request and applies
  // its effect. A hit wins over a free slot; a miss on insert takes the
  // lowest free slot, or reports the table full. Data fields are zero on
  // every reply except a successful get.
  // ---------------------------------------------------------------------------
  function automatic conn_reply_t predict_table_reply(input conn_req_t rq);
    conn_reply_t rp;
    int          hit_slot;
    int          free_idx;
    rp.status = ST_OK;
    rp.pid    = '0;
    rp.ip     = '0;
    rp.port   = '0;
    hit_slot  = -1;
    free_idx  = -1;
    // walk downward, so the lowest free slot is the one left in free_idx
    for (int i = TBL_SLOTS - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == rq.key) hit_slot = i;
      if (!shadow_valid[i]) free_idx = i;
    end
    case (rq.kind)
      REQ_INSERT: begin
        if (hit_slot < 0 && free_idx >= 0) begin
          hit_slot               = free_idx;
          shadow_valid[hit_slot] = 1'b1;
          shadow_key[hit_slot]   = rq.key;
        end
        if (hit_slot < 0) begin
          rp.status = ST_FULL;
        end else begin
          shadow_pid[hit_slot]  = rq.pid;
          shadow_ip[hit_slot]   = rq.ip;
          shadow_port[hit_slot] = rq.port;
        end
      end
      REQ_REMOVE: begin
        if (hit_slot < 0) rp.status = ST_NOTFOUND;
        else shadow_valid[hit_slot] = 1'b0;
      end
      REQ_GET: begin
        if (hit_slot < 0) begin
          rp.status = ST_NOTFOUND;
        end else begin
          rp.pid  = shadow_pid[hit_slot];
          rp.ip   = shadow_ip[hit_slot];
          rp.port = shadow_port[hit_slot];
        end
      end
      default: begin
        // set: an empty enable mask on a present key is still a success
        if (hit_slot < 0) begin
          rp.status = ST_NOTFOUND;
        end else begin
          if (rq.set_pid)  shadow_pid[hit_slot]  = rq.pid;
          if (rq.set_ip)   shadow_ip[hit_slot]   = rq.ip;
          if (rq.set_port) shadow_port[hit_slot] = rq.port;
        end
      end
    endcase
    return rp;
  endfunction

  function automatic conn_req_t make_req(input req_t kind, input logic [KEY_W-1:0] key,
                                         input logic [PID_W-1:0] pid,
                                         input logic [IP_W-1:0] ip,
                                         input logic [PORT_W-1:0] port,
                                         input logic [2:0] set_mask);
    conn_req_t rq;
    rq.kind     = kind;
    rq.key      = key;
    rq.pid      = pid;
    rq.ip       = ip;
    rq.port     = port;
    rq.set_pid  = set_mask[0];
    rq.set_ip   = set_mask[1];
    rq.set_port = set_mask[2];
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one request beat. Inputs move only at the falling edge. Before
  // the beat the sender may idle, with junk on the payload. After the
  // accepting edge valid stays high until the next falling edge, where the
  // next call or hold_off_inputs takes over, so valid never drops and rises
  // again in one step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input conn_req_t rq);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid      = 1'b0;
      in_req_type   = 2'($urandom);
      in_key        = {$urandom, $urandom};
      in_pid_value  = $urandom;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_req_type   = rq.kind;
    in_key        = rq.key;
    in_pid_value  = rq.pid;
    in_ip_value   = rq.ip;
    in_port_value = rq.port;
    in_set_pid    = rq.set_pid;
    in_set_ip     = rq.set_ip;
    in_set_port   = rq.set_port;
    do @(posedge clk); while (in_stall);
    // accepted at this edge: predict now, in acceptance order
    awaited_replies.push_back(predict_table_reply(rq));
    req_count[rq.kind]++;
  endtask

  task automatic hold_off_inputs();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Reply checker: every beat taken at a rising edge is matched against the
  // oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    conn_reply_t exp_rp;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("reply beat with no request waiting: status %0d", out_status);
        mismatches++;
      end else begin
        exp_rp = awaited_replies.pop_front();
        if (out_status !== exp_rp.status) begin
          $error("out_status: expected %0d, got %0d", exp_rp.status, out_status);
          mismatches++;
        end
        if (out_pid !== exp_rp.pid) begin
          $error("out_pid: expected 0x%08h, got 0x%08h", exp_rp.pid, out_pid);
          mismatches++;
        end
        if (out_ip !== exp_rp.ip) begin
          $error("out_ip: expected 0x%08h, got 0x%08h", exp_rp.ip, out_ip);
          mismatches++;
        end
        if (out_port !== exp_rp.port) begin
          $error("out_port: expected 0x%04h, got 0x%04h", exp_rp.port, out_port);
          mismatches++;
        end
        case (exp_rp.status)
          ST_OK:       replies_ok++;
          ST_NOTFOUND: replies_missing++;
          default:     replies_full++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random traffic. Most handles come from the pool, so inserts, updates,
  // hits and removes keep meeting each other. Removes often pick a handle
  // that is resident, which keeps the table from sticking at full. Fully
  // random handles are the noise: mostly misses.
  // ---------------------------------------------------------------------------
  function automatic logic [KEY_W-1:0] pick_handle(input req_t kind);
    int unsigned roll;
    int          resident [$];
    roll = $urandom_range(99);
    for (int i = 0; i < TBL_SLOTS; i++) begin
      if (shadow_valid[i]) resident.push_back(i);
    end
    if (kind == REQ_REMOVE && roll < 50 && resident.size() != 0)
      return shadow_key[resident[$urandom_range(resident.size() - 1)]];
    if (kind != REQ_REMOVE && roll < 5 && resident.size() != 0)
      return shadow_key[resident[$urandom_range(resident.size() - 1)]];
    if (roll < 90)
      return handle_pool[$urandom_range(POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic conn_req_t random_request();
    int unsigned roll;
    req_t        kind;
    roll = $urandom_range(99);
    if (roll < 38)      kind = REQ_INSERT;
    else if (roll < 56) kind = REQ_REMOVE;
    else if (roll < 80) kind = REQ_GET;
    else                kind = REQ_SET;
    return make_req(kind, pick_handle(kind), $urandom, $urandom, 16'($urandom),
                    3'($urandom));
  endfunction

  task automatic random_requests(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) send_request(random_request());
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  localparam logic [KEY_W-1:0] HANDLE_ZERO = '0;
  localparam logic [KEY_W-1:0] HANDLE_ONES = '1;
  localparam logic [KEY_W-1:0] HANDLE_ABSENT = 64'h0123_4567_89AB_CDEF;

  // extreme handles and values; re-insert of a present handle updates it
  task automatic test_insert_update_get();
    send_request(make_req(REQ_INSERT, HANDLE_ZERO, '0, '0, '0, 3'b000));
    send_request(make_req(REQ_INSERT, HANDLE_ONES, '1, '1, '1, 3'b111));
    send_request(make_req(REQ_GET, HANDLE_ZERO, '1, '1, '1, 3'b111));
    send_request(make_req(REQ_INSERT, HANDLE_ZERO, 32'hDEAD_BEEF, 32'hC0A8_0101,
                          16'd443, 3'b000));
    send_request(make_req(REQ_GET, HANDLE_ZERO, '0, '0, '0, 3'b000));
  endtask

  // empty enable mask is a no-op success; then a partial update
  task automatic test_set_enables();
    send_request(make_req(REQ_SET, HANDLE_ONES, '0, '0, '0, 3'b000));
    send_request(make_req(REQ_SET, HANDLE_ONES, 32'h0000_1234, '0, '0, 3'b001));
    send_request(make_req(REQ_SET, HANDLE_ONES, '0, 32'h0A00_0001, 16'd0, 3'b110));
    send_request(make_req(REQ_GET, HANDLE_ONES, '0, '0, '0, 3'b000));
  endtask

  // remove, get and set of a handle that is not in the table
  task automatic test_missing_handle();
    send_request(make_req(REQ_GET, HANDLE_ABSENT, '0, '0, '0, 3'b000));
    send_request(make_req(REQ_REMOVE, HANDLE_ABSENT, '0, '0, '0, 3'b000));
    send_request(make_req(REQ_SET, HANDLE_ABSENT, '1, '1, '1, 3'b111));
  endtask

  // fill every slot, overflow once, then free a slot and reuse it
  task automatic test_table_full();
    for (int i = 2; i < TBL_SLOTS; i++) begin
      send_request(make_req(REQ_INSERT, {32'hA5A5_0000 | 32'(i), ~32'(i)}, $urandom,
                            $urandom, 16'($urandom), 3'($urandom)));
    end
    send_request(make_req(REQ_INSERT, HANDLE_ABSENT, '1, '1, '1, 3'b111));
    send_request(make_req(REQ_REMOVE, HANDLE_ZERO, '0, '0, '0, 3'b000));
    send_request(make_req(REQ_INSERT, HANDLE_ABSENT, 32'd7, 32'hFFFF_FFFE, 16'd1,
                          3'b000));
  endtask

  // ---------------------------------------------------------------------------
  // Random phases, one per pacing pattern
  // ---------------------------------------------------------------------------
  task automatic test_traffic_steady();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_requests(PHASE_REQS);
  endtask

  task automatic test_traffic_sender_gaps();
    send_idle_pct  = 58;
    recv_stall_pct = 0;
    random_requests(PHASE_REQS);
  endtask

  task automatic test_traffic_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    random_requests(PHASE_REQS);
  endtask

  task automatic test_traffic_both_idle();
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    random_requests(PHASE_REQS);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < TBL_SLOTS; i++) shadow_valid[i] = 1'b0;
    handle_pool[0] = HANDLE_ZERO;
    handle_pool[1] = HANDLE_ONES;
    for (int i = 2; i < POOL_SIZE; i++) handle_pool[i] = {$urandom, $urandom};

    // reset first; the block's clearing pass after that shows up as
    // in_stall, which the sender simply waits out
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_insert_update_get();
    test_set_enables();
    test_missing_handle();
    test_table_full();
    test_traffic_steady();
    test_traffic_sender_gaps();
    test_traffic_receiver_stall();
    test_traffic_both_idle();
    hold_off_inputs();

    // drain, then allow one more slot walk for any stray beat
    recv_stall_pct = 0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (TBL_SLOTS + 8) @(posedge clk);

    $display("Covered %0d inserts, %0d removes, %0d gets, %0d sets under four pacing phases",
             req_count[REQ_INSERT], req_count[REQ_REMOVE], req_count[REQ_GET],
             req_count[REQ_SET]);
    $display("Replies: %0d success, %0d not found, %0d table full; %0d field mismatches",
             replies_ok, replies_missing, replies_full, mismatches);
    if (mismatches == 0) begin
      $display("tb_keyed_connection_info_table_core OK");
    end else begin
      $display("tb_keyed_connection_info_table_core NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 1100 requests, each
  // with its block time plus sender gaps and receiver stall)
  initial begin
    #5_000_000;
    $display("tb_keyed_connection_info_table_core NOT OK");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/kcit_pkg.sv
hw/rtl/kcit_tag_search.sv
hw/rtl/keyed_connection_info_table_core.sv
bench/tb_keyed_connection_info_table_core.sv
